>>> src/sfv_pkg.sv
package sfv_pkg;

    // Default position of the unity-gain step in the gain index range.
    localparam int unsigned CENTER_INDEX_DEF = 60;

    // Field widths that are fixed by the item format.
    localparam int unsigned GAIN_W   = 6;
    localparam int unsigned VOL_W    = 7;
    localparam int unsigned SEEN_W   = 8;
    localparam int unsigned HOST_W   = 16;
    localparam int unsigned THRESH_W = 8;

    // Configuration port geometry.
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Channel-status signature.
    localparam logic [3:0] SIG_B16_LO = 4'hF;
    localparam logic [7:0] SIG_B17    = 8'h04;
    localparam logic [7:0] SIG_B18    = 8'h8A;

    // Volume handling.
    localparam logic [VOL_W-1:0]  VOL_MAX     = 7'd100;
    localparam int unsigned       VOL_ROUND   = 50;
    localparam logic [SEEN_W-1:0] VOL_NEVER   = 8'hFF;
    localparam logic [THRESH_W-1:0] COUNT_MAX = 8'hFF;

    // floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for all n below 43690.
    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_W     = 13;
    localparam int unsigned RECIP_SHIFT = 19;

    // Reset values of the configuration registers.
    localparam logic [THRESH_W-1:0] RISE_TH_RST = 8'd3;
    localparam logic [THRESH_W-1:0] FALL_TH_RST = 8'd10;

    typedef enum logic [1:0] {
        CMD_POLL   = 2'd0,
        CMD_SOURCE = 2'd1,
        CMD_REARM  = 2'd2,
        CMD_INVAL  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_APPLY   = 2'd1,
        ACT_ZERO    = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_ENABLED = 2'd0,
        REG_RISE_TH = 2'd1,
        REG_FALL_TH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                enabled;
        logic [THRESH_W-1:0] rise_threshold;
        logic [THRESH_W-1:0] fall_threshold;
    } sfv_cfg_t;

    typedef struct packed {
        action_t           drive_action;
        logic [GAIN_W-1:0] gain_index;
        logic              present_flag;
        logic [SEEN_W-1:0] seen_volume;
        logic              seen_mute;
        logic              volume_changed;
        logic              mute_changed;
        logic              presence_changed;
    } sfv_result_t;

endpackage

>>> src/sfv_if.sv
interface sfv_in_if;
    import sfv_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              spdif_selected;
    logic              locked;
    logic [7:0]        status_byte15;
    logic [7:0]        status_byte16;
    logic [7:0]        status_byte17;
    logic [7:0]        status_byte18;
    logic signed [HOST_W-1:0] host_volume;

    modport source (
        output valid, cmd, spdif_selected, locked, status_byte15, status_byte16,
               status_byte17, status_byte18, host_volume,
        input  ready
    );

    modport sink (
        input  valid, cmd, spdif_selected, locked, status_byte15, status_byte16,
               status_byte17, status_byte18, host_volume,
        output ready
    );
endinterface

interface sfv_out_if;
    import sfv_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        drive_action;
    logic [GAIN_W-1:0] gain_index;
    logic              present_flag;
    logic [SEEN_W-1:0] seen_volume;
    logic              seen_mute;
    logic              volume_changed;
    logic              mute_changed;
    logic              presence_changed;

    modport source (
        output valid, drive_action, gain_index, present_flag, seen_volume, seen_mute,
               volume_changed, mute_changed, presence_changed,
        input  ready
    );

    modport sink (
        input  valid, drive_action, gain_index, present_flag, seen_volume, seen_mute,
               volume_changed, mute_changed, presence_changed,
        output ready
    );
endinterface

>>> src/sfv_queue.sv
module sfv_queue
    import sfv_pkg::*;
#(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/sfv_front.sv
module sfv_front
    import sfv_pkg::*;
#(
    parameter int unsigned CENTER_INDEX = CENTER_INDEX_DEF,
    parameter int unsigned IDX_W        = $clog2(CENTER_INDEX + 1),
    parameter int unsigned PROD_W       = $clog2(100 * CENTER_INDEX + VOL_ROUND + 1),
    parameter int unsigned ENTRY_W      = PROD_W + IDX_W + 2 + 1 + 1 + VOL_W + 1
) (
    input  logic [1:0]               cmd,
    input  logic                     spdif_selected,
    input  logic                     locked,
    input  logic [7:0]               status_byte15,
    input  logic [7:0]               status_byte16,
    input  logic [7:0]               status_byte17,
    input  logic [7:0]               status_byte18,
    input  logic signed [HOST_W-1:0] host_volume,
    output logic [ENTRY_W-1:0]       entry
);

    localparam int unsigned SUM_W = HOST_W + 2;
    localparam logic signed [SUM_W-1:0] HOST_OFS = SUM_W'(CENTER_INDEX * 256);
    localparam logic signed [SUM_W-1:0] HOST_HI  = SUM_W'((CENTER_INDEX + 1) * 256 - 1);
    localparam logic [IDX_W-1:0]        IDX_TOP  = IDX_W'(CENTER_INDEX);

    logic [7:0]              vol_raw;
    logic                    mute;
    logic [VOL_W-1:0]        vol;
    logic                    hit;
    logic [PROD_W-1:0]       prod;
    logic signed [SUM_W-1:0] host_sum;
    logic [IDX_W-1:0]        host_idx;

    // Signature must be present in full and the receiver locked.
    assign hit = locked && (status_byte16[3:0] == SIG_B16_LO)
                 && (status_byte17 == SIG_B17) && (status_byte18 == SIG_B18);

    assign vol_raw = {status_byte15[3:0], status_byte16[7:4]};
    assign mute    = vol_raw[7];
    assign vol     = (vol_raw[6:0] > VOL_MAX) ? VOL_MAX : vol_raw[6:0];

    // Numerator of the rounded scale; the division by 100 happens in the back end.
    assign prod = PROD_W'(vol) * PROD_W'(CENTER_INDEX) + PROD_W'(VOL_ROUND);

    // Host volume shifted to the index range and clamped.
    assign host_sum = SUM_W'(host_volume) + HOST_OFS;

    always_comb
    begin
        if (host_sum < 0)
        begin
            host_idx = '0;
        end
        else if (host_sum > HOST_HI)
        begin
            host_idx = IDX_TOP;
        end
        else
        begin
            host_idx = host_sum[IDX_W+7:8];
        end
    end

    assign entry = {prod, host_idx, cmd, spdif_selected, hit, vol, mute};

endmodule

>>> src/sfv_back.sv
module sfv_back
    import sfv_pkg::*;
#(
    parameter int unsigned CENTER_INDEX = CENTER_INDEX_DEF,
    parameter int unsigned IDX_W        = $clog2(CENTER_INDEX + 1),
    parameter int unsigned PROD_W       = $clog2(100 * CENTER_INDEX + VOL_ROUND + 1),
    parameter int unsigned ENTRY_W      = PROD_W + IDX_W + 2 + 1 + 1 + VOL_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sfv_cfg_t           cfg,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sfv_result_t        result
);

    localparam int unsigned MUL_W = PROD_W + RECIP_W;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CENTER_INDEX);

    logic [PROD_W-1:0] e_prod;
    logic [IDX_W-1:0]  e_host_idx;
    logic [1:0]        e_cmd;
    logic              e_sel;
    logic              e_hit;
    logic [VOL_W-1:0]  e_vol;
    logic              e_mute;

    logic [MUL_W-1:0]  quot_full;
    logic [IDX_W-1:0]  vol_idx;
    logic [THRESH_W-1:0] rise_inc;
    logic [THRESH_W-1:0] fall_inc;

    logic                present_reg;
    logic                present_next;
    logic [THRESH_W-1:0] rise_reg;
    logic [THRESH_W-1:0] rise_next;
    logic [THRESH_W-1:0] fall_reg;
    logic [THRESH_W-1:0] fall_next;
    logic [SEEN_W-1:0]   last_vol_reg;
    logic [SEEN_W-1:0]   last_vol_next;
    logic                last_mute_reg;
    logic                last_mute_next;
    logic                app_valid_reg;
    logic                app_valid_next;
    logic [IDX_W-1:0]    app_idx_reg;
    logic [IDX_W-1:0]    app_idx_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    sfv_result_t         result_reg;

    action_t             act;
    logic [IDX_W-1:0]    gidx;
    logic                vch;
    logic                mch;
    logic                pch;

    assign {e_prod, e_host_idx, e_cmd, e_sel, e_hit, e_vol, e_mute} = q_data;

    // Divide by 100 through a reciprocal multiply.
    assign quot_full = MUL_W'(e_prod) * MUL_W'(RECIP_100);

    always_comb
    begin
        if (quot_full[MUL_W-1:RECIP_SHIFT] > MUL_W'(CENTER_INDEX))
        begin
            vol_idx = IDX_TOP;
        end
        else
        begin
            vol_idx = quot_full[RECIP_SHIFT+IDX_W-1:RECIP_SHIFT];
        end
    end

    assign rise_inc = (rise_reg == COUNT_MAX) ? rise_reg : rise_reg + 1'b1;
    assign fall_inc = (fall_reg == COUNT_MAX) ? fall_reg : fall_reg + 1'b1;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        present_next   = present_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        last_vol_next  = last_vol_reg;
        last_mute_next = last_mute_reg;
        app_valid_next = app_valid_reg;
        app_idx_next   = app_idx_reg;
        act            = ACT_NONE;
        gidx           = '0;
        vch            = 1'b0;
        mch            = 1'b0;
        pch            = 1'b0;

        case (cmd_t'(e_cmd))
            CMD_POLL:
            begin
                if (!cfg.enabled)
                begin
                    if (present_reg)
                    begin
                        present_next   = 1'b0;
                        rise_next      = '0;
                        app_valid_next = 1'b0;
                        pch            = 1'b1;
                        act            = ACT_RESTORE;
                        gidx           = e_host_idx;
                    end
                end
                else if (!e_sel)
                begin
                    if (present_reg)
                    begin
                        present_next   = 1'b0;
                        rise_next      = '0;
                        app_valid_next = 1'b0;
                        pch            = 1'b1;
                    end
                end
                else if (e_hit)
                begin
                    fall_next = '0;
                    rise_next = rise_inc;
                    if (present_reg || (rise_inc >= cfg.rise_threshold))
                    begin
                        pch          = !present_reg;
                        present_next = 1'b1;
                        if (e_mute)
                        begin
                            act            = ACT_ZERO;
                            app_valid_next = 1'b0;
                        end
                        else if (!app_valid_reg || (vol_idx != app_idx_reg))
                        begin
                            act            = ACT_APPLY;
                            gidx           = vol_idx;
                            app_valid_next = 1'b1;
                            app_idx_next   = vol_idx;
                        end
                        if (SEEN_W'(e_vol) != last_vol_reg)
                        begin
                            last_vol_next = SEEN_W'(e_vol);
                            vch           = 1'b1;
                        end
                        if (e_mute != last_mute_reg)
                        begin
                            last_mute_next = e_mute;
                            mch            = 1'b1;
                        end
                    end
                end
                else
                begin
                    rise_next = '0;
                    fall_next = fall_inc;
                    if (present_reg && (fall_inc >= cfg.fall_threshold))
                    begin
                        present_next   = 1'b0;
                        app_valid_next = 1'b0;
                        pch            = 1'b1;
                        act            = ACT_RESTORE;
                        gidx           = e_host_idx;
                    end
                end
            end
            CMD_SOURCE:
            begin
                if (!e_sel)
                begin
                    if (present_reg)
                    begin
                        present_next   = 1'b0;
                        rise_next      = '0;
                        app_valid_next = 1'b0;
                        pch            = 1'b1;
                    end
                end
                else
                begin
                    rise_next = '0;
                    fall_next = '0;
                end
            end
            CMD_REARM:
            begin
                rise_next      = '0;
                fall_next      = '0;
                app_valid_next = 1'b0;
                if (!cfg.enabled && present_reg)
                begin
                    present_next = 1'b0;
                    pch          = 1'b1;
                    act          = ACT_RESTORE;
                    gidx         = e_host_idx;
                end
            end
            CMD_INVAL:
            begin
                app_valid_next = 1'b0;
            end
            default:
            begin
                app_valid_next = app_valid_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 1'b0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            last_vol_reg  <= VOL_NEVER;
            last_mute_reg <= 1'b0;
            app_valid_reg <= 1'b0;
            app_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                present_reg   <= present_next;
                rise_reg      <= rise_next;
                fall_reg      <= fall_next;
                last_vol_reg  <= last_vol_next;
                last_mute_reg <= last_mute_next;
                app_valid_reg <= app_valid_next;
                app_idx_reg   <= app_idx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg.drive_action     <= act;
            result_reg.gain_index       <= GAIN_W'(gidx);
            result_reg.present_flag     <= present_next;
            result_reg.seen_volume      <= last_vol_next;
            result_reg.seen_mute        <= last_mute_next;
            result_reg.volume_changed   <= vch;
            result_reg.mute_changed     <= mch;
            result_reg.presence_changed <= pch;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

>>> src/spdif_status_volume_follower.sv
// Channel | Direction | Handshake             | Carries
// in_ch   | sink      | valid / ready         | command, source flags, status bytes 15..18,
//         |           |                       | host volume
// out_ch  | source    | valid / ready         | drive action, gain index, presence and
//         |           |                       | volume/mute status with change flags
// APB     | slave     | psel/penable, pready=1| enabled, rise and fall thresholds
//
// One item per clock is sustained while out_ch.ready stays high. An accepted item waits in
// the queue until the back end pops it, updates its state and registers the result.
// Reset is asynchronous and active low and clears all control state at once.
// A two-entry queue parts the classifier from the back end; while out_ch is held off,
// the result register and the queue take three items, after which in_ch.ready drops.
module spdif_status_volume_follower
    import sfv_pkg::*;
#(
    parameter int unsigned CENTER_INDEX = CENTER_INDEX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    sfv_in_if.sink             in_ch,
    sfv_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Width of an internal gain index and of the rounded-volume numerator.
    localparam int unsigned IDX_W   = $clog2(CENTER_INDEX + 1);
    localparam int unsigned PROD_W  = $clog2(100 * CENTER_INDEX + VOL_ROUND + 1);
    localparam int unsigned ENTRY_W = PROD_W + IDX_W + 2 + 1 + 1 + VOL_W + 1;

    logic                enabled_reg;
    logic                enabled_next;
    logic [THRESH_W-1:0] rise_th_reg;
    logic [THRESH_W-1:0] rise_th_next;
    logic [THRESH_W-1:0] fall_th_reg;
    logic [THRESH_W-1:0] fall_th_next;

    logic                cfg_write;
    reg_idx_t            reg_sel;
    sfv_cfg_t            cfg;

    logic [ENTRY_W-1:0]  front_entry;
    logic                q_push;
    logic                q_not_full;
    logic                q_not_empty;
    logic                q_pop;
    logic [ENTRY_W-1:0]  q_data;
    sfv_result_t         result;

    // ------------------------------------------------------------------
    // Configuration registers. The port never waits, so pready is tied
    // high and a write lands in the access phase.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        enabled_next = enabled_reg;
        rise_th_next = rise_th_reg;
        fall_th_next = fall_th_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_ENABLED: enabled_next = pwdata[0];
                REG_RISE_TH: rise_th_next = pwdata[THRESH_W-1:0];
                REG_FALL_TH: fall_th_next = pwdata[THRESH_W-1:0];
                default:     enabled_next = enabled_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ENABLED: prdata = PDATA_W'(enabled_reg);
            REG_RISE_TH: prdata = PDATA_W'(rise_th_reg);
            REG_FALL_TH: prdata = PDATA_W'(fall_th_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            rise_th_reg <= RISE_TH_RST;
            fall_th_reg <= FALL_TH_RST;
        end
        else
        begin
            enabled_reg <= enabled_next;
            rise_th_reg <= rise_th_next;
            fall_th_reg <= fall_th_next;
        end
    end

    assign cfg.enabled        = enabled_reg;
    assign cfg.rise_threshold = rise_th_reg;
    assign cfg.fall_threshold = fall_th_reg;

    // ------------------------------------------------------------------
    // Front end: decodes the status bytes, checks the signature and works
    // out the host restore index before the item is queued.
    // ------------------------------------------------------------------
    sfv_front #(
        .CENTER_INDEX (CENTER_INDEX),
        .IDX_W        (IDX_W),
        .PROD_W       (PROD_W),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .cmd            (in_ch.cmd),
        .spdif_selected (in_ch.spdif_selected),
        .locked         (in_ch.locked),
        .status_byte15  (in_ch.status_byte15),
        .status_byte16  (in_ch.status_byte16),
        .status_byte17  (in_ch.status_byte17),
        .status_byte18  (in_ch.status_byte18),
        .host_volume    (in_ch.host_volume),
        .entry          (front_entry)
    );

    // An item is taken whenever the queue has room, independent of the
    // output side.
    assign in_ch.ready = q_not_full;
    assign q_push      = in_ch.valid && q_not_full;

    sfv_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // ------------------------------------------------------------------
    // Back end: hysteresis counters, presence, apply cache and the
    // registered result.
    // ------------------------------------------------------------------
    sfv_back #(
        .CENTER_INDEX (CENTER_INDEX),
        .IDX_W        (IDX_W),
        .PROD_W       (PROD_W),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_not_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .result    (result)
    );

    assign out_ch.drive_action     = result.drive_action;
    assign out_ch.gain_index       = result.gain_index;
    assign out_ch.present_flag     = result.present_flag;
    assign out_ch.seen_volume      = result.seen_volume;
    assign out_ch.seen_mute        = result.seen_mute;
    assign out_ch.volume_changed   = result.volume_changed;
    assign out_ch.mute_changed     = result.mute_changed;
    assign out_ch.presence_changed = result.presence_changed;

endmodule

>>> src/sfv_checker.sv
module sfv_checker
    import sfv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        drive_action,
    input logic [GAIN_W-1:0] gain_index,
    input logic              present_flag,
    input logic              presence_changed
);

    // Gain is only driven while the signature is judged present.
    a_drive_needs_presence: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((drive_action == ACT_APPLY) || (drive_action == ACT_ZERO))
        |-> present_flag)
        else $error("apply or zero gain without presence");

    // Restores only happen on a falling presence.
    a_restore_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (drive_action == ACT_RESTORE) |-> presence_changed && !present_flag)
        else $error("restore without presence falling");

    // No index accompanies an idle or mute action.
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((drive_action == ACT_NONE) || (drive_action == ACT_ZERO))
        |-> (gain_index == '0))
        else $error("gain index set without apply or restore");

    // A stalled result stays on the port.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_action)
        && $stable(gain_index) && $stable(present_flag))
        else $error("stalled result changed");

endmodule

bind spdif_status_volume_follower sfv_checker u_sfv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .drive_action     (out_ch.drive_action),
    .gain_index       (out_ch.gain_index),
    .present_flag     (out_ch.present_flag),
    .presence_changed (out_ch.presence_changed)
);
